// ===== src/rap_pkg.sv =====
// Shared types and fixed constants for the receive array partitioner.
package rap_pkg;

    // Reduction floors.
    localparam int unsigned FLOOR_NET_CONTEXTS = 2;
    localparam int unsigned FLOOR_ENTRIES      = 1024;
    localparam int unsigned FLOOR_TID_GROUPS   = 2;

    typedef struct packed {
        logic [7:0]  eager_contexts;
        logic [7:0]  network_contexts;
        logic [7:0]  tid_contexts;
        logic [15:0] max_eager_buffers;
        logic        hold_eager;
    } rap_in_t;

    typedef struct packed {
        logic [13:0] eager_groups_each;
        logic [8:0]  network_groups_each;
        logic [8:0]  tid_groups_each;
        logic [13:0] eager_pool_total;
        logic [13:0] network_pool_total;
        logic [13:0] tid_pool_total;
        logic [7:0]  network_contexts_kept;
        logic        fits;
    } rap_out_t;

endpackage

// ===== src/receive_array_partitioner_core.sv =====
// Receive array partitioner: sizes the eager, network and tid pools of the receive array.
//
//   channel   ports                          direction  meaning
//   -------   -----------------------------  ---------  ---------------------------------
//   config    cfg_wr_en, cfg_wr_data         in         array entries, written any cycle
//   request   s_valid, s_ready, s_data       in         one sizing request word
//   result    m_valid, m_ready, m_data       out        one partition result word
//
// Each reduction pass adds to the time a request takes; the passes are bounded by how far
// tid groups can be decremented. The cost is set by the shared 16-step restoring divider
// (up to six divisions per request) and the sequencer stepping one reduction at a time
// through one shared multiplier.
// Reset is synchronous and active low; the array size returns to 32768 entries.
// A result waiting in the output register does not stop the next request from being
// accepted; only the final load waits for that register to drain.
module receive_array_partitioner_core
    import rap_pkg::*;
#(
    parameter int GROUP_ENTRIES          = 8,
    parameter int MAX_GROUPS_PER_CONTEXT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  rap_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rap_out_t    m_data
);

    localparam int CAPW        = $clog2(MAX_GROUPS_PER_CONTEXT + 1);
    localparam int PROD_W      = CAPW + 8;
    localparam int SUM_W       = (PROD_W + 2 > 17) ? PROD_W + 2 : 17;
    localparam int FLOOR_GROUPS = FLOOR_ENTRIES / GROUP_ENTRIES;
    localparam logic [16:0] CAP_V = 17'(MAX_GROUPS_PER_CONTEXT);
    localparam logic [7:0]  GE_V  = 8'(GROUP_ENTRIES);
    localparam logic [3:0]  DIV_LAST = 4'd15;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_TE_INIT, S_TE_CAP, S_EE_INIT, S_EE_CAP,
        S_INIT_E, S_INIT_N, S_MUL, S_CHECK,
        S_XT, S_XT_ADD, S_XN, S_XN_ADD, S_XE, S_XE_ADD, S_DONE
    } state_t;

    typedef enum logic [1:0] {K_TID, K_NET, K_EAGER} kind_t;

    typedef enum logic [2:0] {RED_NCTX, RED_NET, RED_EAGER, RED_TID, RED_END} step_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    kind_t  mul_sel_reg, mul_sel_next;
    step_t  step_reg, step_next;
    logic   changed_reg, changed_next, fits_reg, fits_next;
    logic   m_valid_reg, m_valid_next;

    logic [15:0] array_entries_reg;
    rap_in_t     in_reg, in_next;
    rap_out_t    out_reg, out_next;
    logic [7:0]  ne_ctx_reg, ne_ctx_next;
    logic [15:0] groups_reg, groups_next;
    logic [CAPW-1:0] te_reg, te_next, ne_reg, ne_next;
    logic [16:0] ee_reg, ee_next;
    logic [PROD_W-1:0] tot_ee_reg, tot_ee_next, tot_ne_reg, tot_ne_next;
    logic [PROD_W-1:0] tot_te_reg, tot_te_next;

    logic [7:0]  div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [15:0] div_quo_reg, div_quo_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;

    logic [8:0]  div_shift;
    logic        div_take;
    logic [CAPW-1:0] mul_a;
    logic [7:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [SUM_W-1:0] sum;
    logic        fit;
    logic [15:0] extra;
    logic [16:0] q_ext, add_val, q_cap, add_cap;

    // Divider datapath: one restoring step per cycle.
    assign div_shift = {div_rem_reg, div_quo_reg[15]};
    assign div_take  = div_shift >= {1'b0, div_den_reg};

    always_comb begin
        case (mul_sel_reg)
            K_TID: begin
                mul_a = te_reg;
                mul_b = in_reg.tid_contexts;
            end
            K_NET: begin
                mul_a = ne_reg;
                mul_b = ne_ctx_reg;
            end
            K_EAGER: begin
                mul_a = ee_reg[CAPW-1:0];
                mul_b = in_reg.eager_contexts;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign sum   = SUM_W'(tot_ee_reg) + SUM_W'(tot_ne_reg) + SUM_W'(tot_te_reg);
    assign fit   = sum <= SUM_W'(groups_reg);
    assign extra = 16'(SUM_W'(groups_reg) - sum);

    assign q_ext   = {1'b0, div_quo_reg};
    assign q_cap   = (q_ext > CAP_V) ? CAP_V : q_ext;
    assign add_val = (mul_sel_reg == K_TID) ? 17'(te_reg) + q_ext : 17'(ne_reg) + q_ext;
    assign add_cap = (add_val > CAP_V) ? CAP_V : add_val;

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        mul_sel_next = mul_sel_reg;
        step_next    = step_reg;
        changed_next = changed_reg;
        fits_next    = fits_reg;
        m_valid_next = m_valid_reg;
        in_next      = in_reg;
        out_next     = out_reg;
        ne_ctx_next  = ne_ctx_reg;
        groups_next  = groups_reg;
        te_next      = te_reg;
        ne_next      = ne_reg;
        ee_next      = ee_reg;
        tot_ee_next  = tot_ee_reg;
        tot_ne_next  = tot_ne_reg;
        tot_te_next  = tot_te_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_quo_next = div_quo_reg;
        div_cnt_next = div_cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next      = s_data;
                    ne_ctx_next  = s_data.network_contexts;
                    fits_next    = 1'b0;
                    changed_next = 1'b0;
                    step_next    = RED_NCTX;
                    div_quo_next = array_entries_reg;
                    div_rem_next = '0;
                    div_den_next = GE_V;
                    div_cnt_next = '0;
                    ret_next     = S_TE_INIT;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                div_rem_next = div_take ? 8'(div_shift - {1'b0, div_den_reg}) : div_shift[7:0];
                div_quo_next = {div_quo_reg[14:0], div_take};
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ret_reg;
                end
            end
            S_TE_INIT: begin
                groups_next = div_quo_reg;
                if (in_reg.tid_contexts != 8'd0) begin
                    div_quo_next = div_quo_reg;
                    div_rem_next = '0;
                    div_den_next = in_reg.tid_contexts;
                    div_cnt_next = '0;
                    ret_next     = S_TE_CAP;
                    state_next   = S_DIV;
                end else begin
                    te_next    = '0;
                    state_next = S_EE_INIT;
                end
            end
            S_TE_CAP: begin
                te_next    = CAPW'(q_cap);
                state_next = S_EE_INIT;
            end
            S_EE_INIT: begin
                div_quo_next = in_reg.max_eager_buffers;
                div_rem_next = '0;
                div_den_next = GE_V;
                div_cnt_next = '0;
                ret_next     = S_EE_CAP;
                state_next   = S_DIV;
            end
            S_EE_CAP: begin
                ee_next      = q_cap;
                ne_next      = CAPW'(MAX_GROUPS_PER_CONTEXT);
                mul_sel_next = K_TID;
                ret_next     = S_INIT_E;
                state_next   = S_MUL;
            end
            S_INIT_E: begin
                mul_sel_next = K_EAGER;
                ret_next     = S_INIT_N;
                state_next   = S_MUL;
            end
            S_INIT_N: begin
                mul_sel_next = K_NET;
                ret_next     = S_CHECK;
                state_next   = S_MUL;
            end
            S_MUL: begin
                case (mul_sel_reg)
                    K_TID:   tot_te_next = mul_p;
                    K_NET:   tot_ne_next = mul_p;
                    K_EAGER: tot_ee_next = mul_p;
                    default: tot_te_next = tot_te_reg;
                endcase
                state_next = ret_reg;
            end
            S_CHECK: begin
                if (fit) begin
                    fits_next  = 1'b1;
                    state_next = S_XT;
                end else begin
                    // Each reduction, when it applies, refreshes its pool total and
                    // comes back here for the fit test that follows it.
                    ret_next = S_CHECK;
                    case (step_reg)
                        RED_NCTX: begin
                            step_next = RED_NET;
                            if (32'(ne_ctx_reg) > FLOOR_NET_CONTEXTS) begin
                                ne_ctx_next  = ne_ctx_reg >> 1;
                                changed_next = 1'b1;
                                mul_sel_next = K_NET;
                                state_next   = S_MUL;
                            end
                        end
                        RED_NET: begin
                            step_next = RED_EAGER;
                            if (32'(ne_reg) > FLOOR_GROUPS) begin
                                ne_next      = ne_reg >> 1;
                                changed_next = 1'b1;
                                mul_sel_next = K_NET;
                                state_next   = S_MUL;
                            end
                        end
                        RED_EAGER: begin
                            step_next = RED_TID;
                            if (!in_reg.hold_eager && 32'(ee_reg) > FLOOR_GROUPS) begin
                                ee_next      = ee_reg >> 1;
                                changed_next = 1'b1;
                                mul_sel_next = K_EAGER;
                                state_next   = S_MUL;
                            end
                        end
                        RED_TID: begin
                            step_next = RED_END;
                            if (32'(te_reg) > FLOOR_TID_GROUPS) begin
                                te_next      = te_reg - CAPW'(1);
                                changed_next = 1'b1;
                                mul_sel_next = K_TID;
                                state_next   = S_MUL;
                            end
                        end
                        RED_END: begin
                            if (!changed_reg) begin
                                state_next = S_DONE;
                            end else begin
                                changed_next = 1'b0;
                                step_next    = RED_NCTX;
                            end
                        end
                        default: step_next = RED_NCTX;
                    endcase
                end
            end
            S_XT: begin
                mul_sel_next = K_TID;
                if (in_reg.tid_contexts != 8'd0) begin
                    div_quo_next = extra;
                    div_rem_next = '0;
                    div_den_next = in_reg.tid_contexts;
                    div_cnt_next = '0;
                    ret_next     = S_XT_ADD;
                    state_next   = S_DIV;
                end else begin
                    state_next = S_XN;
                end
            end
            S_XT_ADD: begin
                te_next    = CAPW'(add_cap);
                ret_next   = S_XN;
                state_next = S_MUL;
            end
            S_XN: begin
                mul_sel_next = K_NET;
                if (ne_ctx_reg != 8'd0) begin
                    div_quo_next = extra;
                    div_rem_next = '0;
                    div_den_next = ne_ctx_reg;
                    div_cnt_next = '0;
                    ret_next     = S_XN_ADD;
                    state_next   = S_DIV;
                end else begin
                    state_next = S_XE;
                end
            end
            S_XN_ADD: begin
                ne_next    = CAPW'(add_cap);
                ret_next   = S_XE;
                state_next = S_MUL;
            end
            S_XE: begin
                if (in_reg.eager_contexts != 8'd0) begin
                    div_quo_next = extra;
                    div_rem_next = '0;
                    div_den_next = in_reg.eager_contexts;
                    div_cnt_next = '0;
                    ret_next     = S_XE_ADD;
                    state_next   = S_DIV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_XE_ADD: begin
                // The eager share is not capped.
                ee_next    = ee_reg + q_ext;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.eager_groups_each     = 14'(ee_reg);
                    out_next.network_groups_each   = 9'(ne_reg);
                    out_next.tid_groups_each       = 9'(te_reg);
                    out_next.eager_pool_total      = 14'(tot_ee_reg);
                    out_next.network_pool_total    = 14'(tot_ne_reg);
                    out_next.tid_pool_total        = 14'(tot_te_reg);
                    out_next.network_contexts_kept = ne_ctx_reg;
                    out_next.fits                  = fits_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ret_reg           <= S_IDLE;
            mul_sel_reg       <= K_TID;
            step_reg          <= RED_NCTX;
            changed_reg       <= 1'b0;
            fits_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
            array_entries_reg <= 16'd32768;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            mul_sel_reg <= mul_sel_next;
            step_reg    <= step_next;
            changed_reg <= changed_next;
            fits_reg    <= fits_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                array_entries_reg <= cfg_wr_data;
            end
        end
        in_reg      <= in_next;
        out_reg     <= out_next;
        ne_ctx_reg  <= ne_ctx_next;
        groups_reg  <= groups_next;
        te_reg      <= te_next;
        ne_reg      <= ne_next;
        ee_reg      <= ee_next;
        tot_ee_reg  <= tot_ee_next;
        tot_ne_reg  <= tot_ne_next;
        tot_te_reg  <= tot_te_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_quo_reg <= div_quo_next;
        div_cnt_reg <= div_cnt_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A partition reported as fitting never overcommits the array.
    a_fit_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && fits_reg) |-> (sum <= SUM_W'(groups_reg)))
        else $error("fitting partition exceeds the group count");

    // The divider's partial remainder stays below its divisor.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_rem_reg < div_den_reg))
        else $error("divider remainder out of range");

    // Network and tid sizes never pass the per-context cap once the loop runs.
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (17'(te_reg) <= CAP_V && 17'(ne_reg) <= CAP_V))
        else $error("per-context size above cap");

    // An accepted request always starts with the group-count division.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DIV && ret_reg == S_TE_INIT))
        else $error("request did not start the sequencer");

endmodule
